// File: rtl/hufenc_pkg.sv
`default_nettype none

package hufenc_pkg;

	// Table geometry and code length bound.
	localparam int MAX_CODE_LEN = 32;
	localparam int SYMBOL_COUNT = 256;
	localparam int CODE_W       = 32;
	localparam int LEN_W        = 6;
	localparam int SYM_W        = 8;
	localparam int BYTE_W       = 8;
	localparam int ADDR_W       = (SYMBOL_COUNT > 1) ? $clog2(SYMBOL_COUNT) : 1;
	localparam int ENTRY_W      = CODE_W + LEN_W;

	// A code may be no longer than the bound or the width of the code field.
	localparam int LEN_LIMIT = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

	// Pending bits never reach a full byte, and one item gives at most this many bytes.
	localparam int PEND_W = BYTE_W - 1;
	localparam int CNT_W  = $clog2(BYTE_W);
	localparam int ACC_W  = PEND_W + CODE_W;
	localparam int EMIT_W = CODE_W;
	localparam int RES_W  = $clog2(ACC_W / BYTE_W + 1);

	typedef enum logic [1:0] {
		ACT_LOAD   = 2'd0,
		ACT_ENCODE = 2'd1,
		ACT_FLUSH  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		ST_DATA     = 2'd0,
		ST_MISSING  = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

endpackage

`default_nettype wire

// File: rtl/hufenc_if.sv
`default_nettype none

interface hufenc_item_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  symbol;
	logic [31:0] code_bits;
	logic [5:0]  code_length;

	modport source (output valid, action, symbol, code_bits, code_length, input ready);
	modport sink (input valid, action, symbol, code_bits, code_length, output ready);
endinterface

interface hufenc_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] status;
	logic       last;

	modport source (output valid, out_byte, status, last, input ready);
	modport sink (input valid, out_byte, status, last, output ready);
endinterface

`default_nettype wire

// File: rtl/hufenc_ram.sv
`default_nettype none

module hufenc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic                                   re,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/huffman_table_encoder_packer.sv
`default_nettype none

// Huffman table encoder with an LSB-first byte packer. Load beats write one
// symbol's code and length into the table; encode beats look the symbol up and
// append its code, code bit 0 first, to the packer; flush beats emit the partial
// last byte padded with zeros. Each result beat carries a byte and a status,
// and last marks the final result beat caused by one input beat. The table
// sits in a synchronous RAM read at the accepting edge, and an input beat
// passes through stage 1 and then the output register before its result beat
// is presented. The valid marks are flip-flops cleared by reset, so the block
// is ready straight after reset with no clearing pass. One input beat is taken
// every cycle as long as each beat yields at most one result and the sink is
// ready; a beat that yields n result beats (up to four bytes for a long code)
// holds the output register until its n bytes are taken, and the input waits
// while those bytes drain.
module huffman_table_encoder_packer
	import hufenc_pkg::*;
(
	input wire logic        clk,
	input wire logic        arst_n,
	hufenc_item_if.sink     items,
	hufenc_result_if.source results
);

	// Valid marks for the table entries, cleared at reset.
	logic [SYMBOL_COUNT-1:0] entry_valid_q;

	// Stage 1: the accepted beat, with the table entry arriving from the RAM.
	logic                  valid_s1;
	action_t               action_s1;
	logic                  hit_s1;
	logic                  too_long_s1;
	logic [ENTRY_W-1:0]    entry_s1;

	// Packer state and the output register holding the bytes still to be sent.
	logic [PEND_W-1:0]     pend_bits_q;
	logic [CNT_W-1:0]      pend_cnt_q;
	logic [RES_W-1:0]      em_cnt_q;
	logic [EMIT_W-1:0]     em_data_q;
	status_t               em_status_q;

	logic                  accept;
	logic                  in_range;
	logic                  in_too_long;
	logic                  table_we;
	logic [ADDR_W-1:0]     addr;
	logic                  consume;
	logic                  move_s1;

	// Packing of the beat in stage 1.
	logic [CODE_W-1:0]     code;
	logic [LEN_W-1:0]      clen;
	logic [CODE_W-1:0]     mask;
	logic [ACC_W-1:0]      acc;
	logic [ACC_W-1:0]      rest;
	logic [LEN_W-1:0]      total;
	logic [RES_W-1:0]      nb;
	logic [RES_W-1:0]      new_cnt;
	logic [EMIT_W-1:0]     new_data;
	status_t               new_status;
	logic                  pend_upd;
	logic [PEND_W-1:0]     new_pend_bits;
	logic [CNT_W-1:0]      new_pend_cnt;

	assign accept      = items.valid && items.ready;
	assign addr        = items.symbol[ADDR_W-1:0];
	assign in_range    = {1'b0, items.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
	assign in_too_long = items.code_length > LEN_W'(LEN_LIMIT);
	assign table_we    = accept && (action_t'(items.action) == ACT_LOAD)
		&& !in_too_long && in_range;

	// The RAM is read only when a beat is taken, so its output holds while
	// stage 1 is stalled. A load and a later encode of the same symbol never
	// meet in one cycle, so the read always sees the finished write.
	hufenc_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (SYMBOL_COUNT)
	) u_table (
		.clk   (clk),
		.we    (table_we),
		.waddr (addr),
		.wdata ({items.code_length, items.code_bits}),
		.re    (accept),
		.raddr (addr),
		.rdata (entry_s1)
	);

	// The output register may be refilled once it is empty or sending its
	// last byte in this cycle; stage 1 moves on only then, which keeps the
	// packer updates in order.
	assign consume     = (em_cnt_q != '0) && results.ready;
	assign move_s1     = valid_s1 && ((em_cnt_q == '0)
		|| ((em_cnt_q == RES_W'(1)) && results.ready));
	assign items.ready = !valid_s1 || move_s1;

	assign code  = entry_s1[CODE_W-1:0];
	assign clen  = entry_s1[ENTRY_W-1:CODE_W];
	// Code bits above the stored length are dropped.
	assign mask  = ~CODE_W'({(CODE_W + 1){1'b1}} << clen);
	assign acc   = ACC_W'(pend_bits_q) | (ACC_W'(code & mask) << pend_cnt_q);
	assign total = LEN_W'(pend_cnt_q) + clen;
	assign nb    = RES_W'(total >> CNT_W);
	assign rest  = acc >> {nb, CNT_W'(0)};

	always_comb begin
		new_cnt       = '0;
		new_data      = '0;
		new_status    = ST_DATA;
		pend_upd      = 1'b0;
		new_pend_bits = pend_bits_q;
		new_pend_cnt  = pend_cnt_q;
		unique case (action_s1)
			ACT_LOAD: begin
				if (too_long_s1) begin
					new_cnt    = RES_W'(1);
					new_status = ST_TOO_LONG;
				end
			end
			ACT_ENCODE: begin
				if (!hit_s1) begin
					new_cnt    = RES_W'(1);
					new_status = ST_MISSING;
				end else begin
					new_cnt       = nb;
					new_data      = acc[EMIT_W-1:0];
					pend_upd      = 1'b1;
					new_pend_bits = rest[PEND_W-1:0];
					new_pend_cnt  = total[CNT_W-1:0];
				end
			end
			ACT_FLUSH: begin
				if (pend_cnt_q != '0) begin
					new_cnt       = RES_W'(1);
					new_data      = EMIT_W'(pend_bits_q);
					pend_upd      = 1'b1;
					new_pend_bits = '0;
					new_pend_cnt  = '0;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			valid_s1      <= 1'b0;
			pend_bits_q   <= '0;
			pend_cnt_q    <= '0;
			em_cnt_q      <= '0;
		end else begin
			if (table_we) begin
				entry_valid_q[addr] <= 1'b1;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (move_s1) begin
				valid_s1 <= 1'b0;
			end
			if (move_s1 && pend_upd) begin
				pend_bits_q <= new_pend_bits;
				pend_cnt_q  <= new_pend_cnt;
			end
			if (move_s1) begin
				em_cnt_q <= new_cnt;
			end else if (consume) begin
				em_cnt_q <= em_cnt_q - RES_W'(1);
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1   <= action_t'(items.action);
			hit_s1      <= in_range && entry_valid_q[addr];
			too_long_s1 <= in_too_long;
		end
		if (move_s1) begin
			em_data_q   <= new_data;
			em_status_q <= new_status;
		end else if (consume) begin
			em_data_q <= em_data_q >> BYTE_W;
		end
	end

	assign results.valid    = em_cnt_q != '0;
	assign results.out_byte = em_data_q[BYTE_W-1:0];
	assign results.status   = 2'(em_status_q);
	assign results.last     = em_cnt_q == RES_W'(1);

endmodule

`default_nettype wire

// File: rtl/hufenc_chk.sv
`default_nettype none

module hufenc_chk
	import hufenc_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] res_byte,
	input wire logic [1:0] res_status,
	input wire logic       res_last
);

	// A result beat waiting for the sink keeps its contents.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte)
		&& $stable(res_status) && $stable(res_last))
		else $error("result beat changed while stalled");

	// Error results stand alone.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status != 2'(ST_DATA)) |-> res_last)
		else $error("error result not marked last");

	// Error results carry a zero byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (res_status != 2'(ST_DATA)) |-> (res_byte == 8'd0))
		else $error("error result with non-zero byte");

	// Bytes of one encode follow each other without a gap.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> res_valid
		&& (res_status == 2'(ST_DATA)))
		else $error("gap inside a multi-byte result");

endmodule

bind huffman_table_encoder_packer hufenc_chk u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.res_valid  (results.valid),
	.res_ready  (results.ready),
	.res_byte   (results.out_byte),
	.res_status (results.status),
	.res_last   (results.last)
);

`default_nettype wire
